/* hdl/recycling_id_allocator_defines.svh */
// Assertion macros for the verification files of the ID allocator.
// Depends on nothing; included by the checker that is bound to the top level.
`ifndef RECYCLING_ID_ALLOCATOR_DEFINES_SVH
`define RECYCLING_ID_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RIA_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RIA_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* hdl/ria_pkg.sv */
// Shared types, field widths and codes for the recycling ID allocator.
// Depends on nothing; imported by the allocator, its free stack, entry table and checker.
`timescale 1ns / 1ps

package ria_pkg;

    localparam int ID_BITS         = 10;
    localparam int HANDLE_BITS     = 32;
    localparam int STACK_DEPTH_DEF = 1024;
    localparam int ACT_BITS        = 3;
    localparam int STATUS_BITS     = 3;

    typedef logic [ID_BITS-1:0]     id_t;
    typedef logic [HANDLE_BITS-1:0] handle_t;
    typedef logic [ACT_BITS-1:0]    action_t;
    typedef logic [STATUS_BITS-1:0] status_t;

    // The all-ones ID is reserved; the value just below it is the highest ID handed out.
    localparam id_t ID_MAX  = '1;
    localparam id_t ID_LAST = ID_MAX - 1'b1;

    localparam action_t ACT_ALLOC  = 3'd0;
    localparam action_t ACT_FREE   = 3'd1;
    localparam action_t ACT_LOOKUP = 3'd2;
    localparam action_t ACT_PEEK   = 3'd3;
    localparam action_t ACT_HWM    = 3'd4;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_RESERVED  = 3'd1;
    localparam status_t ST_ABSENT    = 3'd2;
    localparam status_t ST_EXHAUSTED = 3'd3;
    localparam status_t ST_FULL      = 3'd4;

    typedef struct packed {
        action_t action;
        id_t     id;
        handle_t handle;
    } ria_req_t;

    typedef struct packed {
        id_t     result_id;
        handle_t result_handle;
        status_t status;
    } ria_rsp_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic empty_next;
    } stk_stat_t;

    typedef struct packed {
        logic valid_we;
        logic valid_bit;
        logic handle_we;
    } tbl_wr_t;

endpackage

/* hdl/ria_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the free stack and the entry tables.
`timescale 1ns / 1ps

module ria_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old contents when the same address is written.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/ria_free_stack.sv */
// LIFO of freed IDs: top entry held in a register, the rest in a RAM read ahead.
// Depends on ria_pkg and ria_ram.
`timescale 1ns / 1ps

module ria_free_stack #(
    parameter int DEPTH = ria_pkg::STACK_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ria_pkg::stk_cmd_t   cmd,
    input  ria_pkg::id_t        push_id,
    output ria_pkg::id_t        top,
    output ria_pkg::id_t        top_next,
    output ria_pkg::stk_stat_t  stat
);
    import ria_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    logic [CNT_W-1:0]  count_reg, count_next, count_m1, count_m2;
    id_t               top_reg, top_nx;
    id_t               ram_rdata, below;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic              byp_sel_reg, byp_sel_next;
    id_t               byp_data_reg;

    // The entry just below the top, as it stands in this cycle.
    assign below = byp_sel_reg ? byp_data_reg : ram_rdata;

    always_comb begin
        if (cmd.push) begin
            count_next = count_reg + 1'b1;
            top_nx     = push_id;
        end else if (cmd.pop) begin
            count_next = count_reg - 1'b1;
            top_nx     = below;
        end else begin
            count_next = count_reg;
            top_nx     = top_reg;
        end
    end

    // A push spills the old top into the RAM slot count-1.
    assign count_m1  = count_reg - 1'b1;
    assign ram_we    = cmd.push && (count_reg != '0);
    assign ram_waddr = count_m1[ADDR_W-1:0];

    // Read ahead the slot that will sit below the top in the next cycle.
    assign count_m2  = count_next - CNT_W'(2);
    assign ram_raddr = (count_next >= CNT_W'(2)) ? count_m2[ADDR_W-1:0] : '0;

    assign byp_sel_next = ram_we && (ram_waddr == ram_raddr);

    ria_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            byp_sel_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            byp_sel_reg <= byp_sel_next;
        end
        top_reg      <= top_nx;
        byp_data_reg <= top_reg;
    end

    assign top             = top_reg;
    assign top_next        = top_nx;
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CNT_W'(DEPTH));
    assign stat.empty_next = (count_next == '0);

endmodule

/* hdl/ria_entry_table.sv */
// Per-ID valid bits and bound handles, with a clearing sweep of the valid bits after reset.
// Depends on ria_pkg and ria_ram.
`timescale 1ns / 1ps

module ria_entry_table (
    input  logic             aclk,
    input  logic             aresetn,
    input  ria_pkg::tbl_wr_t wr,
    input  ria_pkg::id_t     wr_addr,
    input  ria_pkg::handle_t wr_handle,
    input  ria_pkg::id_t     rd_addr,
    output logic             rd_valid,
    output ria_pkg::handle_t rd_handle,
    output logic             clearing
);
    import ria_pkg::*;

    localparam int ID_COUNT = 1 << ID_BITS;

    logic    clr_reg, clr_next;
    id_t     clr_addr_reg;
    logic    v_we, v_wdata, v_rdata;
    id_t     v_waddr;
    handle_t h_rdata;
    logic    v_byp_sel_reg, v_byp_data_reg;
    logic    h_byp_sel_reg;
    handle_t h_byp_data_reg;

    assign v_we    = clr_reg || wr.valid_we;
    assign v_waddr = clr_reg ? clr_addr_reg : wr_addr;
    assign v_wdata = clr_reg ? 1'b0 : wr.valid_bit;

    assign clr_next = clr_reg && (clr_addr_reg != ID_MAX);

    ria_ram #(
        .WIDTH (1),
        .DEPTH (ID_COUNT)
    ) u_valid_ram (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (rd_addr),
        .rdata (v_rdata)
    );

    ria_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (ID_COUNT)
    ) u_handle_ram (
        .aclk  (aclk),
        .we    (wr.handle_we),
        .waddr (wr_addr),
        .wdata (wr_handle),
        .raddr (rd_addr),
        .rdata (h_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= 1'b1;
            clr_addr_reg  <= '0;
            v_byp_sel_reg <= 1'b0;
            h_byp_sel_reg <= 1'b0;
        end else begin
            clr_reg       <= clr_next;
            clr_addr_reg  <= clr_addr_reg + 1'b1;
            v_byp_sel_reg <= v_we && (v_waddr == rd_addr);
            h_byp_sel_reg <= wr.handle_we && (wr_addr == rd_addr);
        end
        v_byp_data_reg <= v_wdata;
        h_byp_data_reg <= wr_handle;
    end

    assign rd_valid  = v_byp_sel_reg ? v_byp_data_reg : v_rdata;
    assign rd_handle = h_byp_sel_reg ? h_byp_data_reg : h_rdata;
    assign clearing  = clr_reg;

endmodule

/* hdl/recycling_id_allocator.sv */
// Top level of the recycling ID allocator: input register, request execution, result register.
// Depends on ria_pkg, ria_free_stack and ria_entry_table.
`timescale 1ns / 1ps

// The allocator hands out IDs, binds each to a handle and takes them back. One
// transaction is accepted per cycle while the consumer takes results: the request
// is captured in an input register, executed against the high-water mark, the
// free stack and the per-ID tables once the result register is free, and
// the result is held in an output register until the consumer takes it. The rate
// is set by the free stack, whose top is kept in a register while the RAM below
// it is read one entry ahead, and by the entry tables, whose single read port is
// addressed for the next request (the ID that an allocate will receive is known
// in advance from the updated stack and high-water mark). Writes that
// collide with that read are forwarded, so back-to-back requests on the same ID
// see each other. After reset the valid bits of all 2^ID_BITS entries (1024 for
// the default build) are cleared one per cycle; s_ready stays low until all are
// cleared. IDs 0 and all-ones are reserved and never handed out.

module recycling_id_allocator #(
    parameter int STACK_DEPTH = ria_pkg::STACK_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ria_pkg::ria_req_t s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output ria_pkg::ria_rsp_t m_payload
);
    import ria_pkg::*;

    // Pipeline registers.
    logic     in_valid_reg, in_valid_next;
    ria_req_t in_data_reg, in_data_next;
    logic     out_valid_reg, out_valid_next;
    ria_rsp_t out_data_reg, out_data_next;
    id_t      hw_reg, hw_next;

    logic      accept, exec, clearing;
    stk_cmd_t  stk_cmd, stk_cmd_g;
    stk_stat_t stk_stat;
    id_t       stk_top, stk_top_next;
    tbl_wr_t   tbl_wr, tbl_wr_g;
    id_t       tbl_wr_addr, tbl_rd_addr;
    logic      tbl_rd_valid;
    handle_t   tbl_rd_handle;
    id_t       hw_exec, nid, nid_next;
    logic      exhausted, reserved;
    ria_rsp_t  rsp;

    // The request in the input register executes whenever the result register
    // is empty or being emptied in this cycle.
    assign exec    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !clearing && (!in_valid_reg || exec);
    assign accept  = s_valid && s_ready;

    // The ID the next allocate would return, from the current state.
    assign nid       = stk_stat.empty ? (hw_reg + 1'b1) : stk_top;
    assign exhausted = stk_stat.empty && (hw_reg >= ID_LAST);
    assign reserved  = (in_data_reg.id == '0) || (in_data_reg.id == ID_MAX);

    always_comb begin
        stk_cmd           = '0;
        tbl_wr            = '0;
        tbl_wr_addr       = in_data_reg.id;
        hw_exec           = hw_reg;
        rsp.result_id     = in_data_reg.id;
        rsp.result_handle = '0;
        rsp.status        = ST_OK;
        unique case (in_data_reg.action)
            ACT_ALLOC: begin
                if (exhausted) begin
                    rsp.result_id = '0;
                    rsp.status    = ST_EXHAUSTED;
                end else begin
                    stk_cmd.pop = !stk_stat.empty;
                    if (stk_stat.empty) begin
                        hw_exec = nid;
                    end
                    // A still-valid entry (after a double free) keeps its binding.
                    tbl_wr_addr      = nid;
                    tbl_wr.valid_we  = !tbl_rd_valid;
                    tbl_wr.valid_bit = 1'b1;
                    tbl_wr.handle_we = !tbl_rd_valid;
                    rsp.result_id    = nid;
                end
            end
            ACT_FREE: begin
                if (reserved) begin
                    rsp.status = ST_RESERVED;
                end else if (in_data_reg.id == hw_reg) begin
                    hw_exec         = hw_reg - 1'b1;
                    tbl_wr.valid_we = 1'b1;
                end else if (stk_stat.full) begin
                    rsp.status = ST_FULL;
                end else begin
                    stk_cmd.push    = 1'b1;
                    tbl_wr.valid_we = 1'b1;
                end
            end
            ACT_LOOKUP: begin
                if (reserved) begin
                    rsp.status = ST_RESERVED;
                end else if (!tbl_rd_valid) begin
                    rsp.status = ST_ABSENT;
                end else begin
                    rsp.result_handle = tbl_rd_handle;
                end
            end
            ACT_PEEK: begin
                if (exhausted) begin
                    rsp.result_id = '0;
                    rsp.status    = ST_EXHAUSTED;
                end else begin
                    rsp.result_id = nid;
                end
            end
            ACT_HWM: begin
                rsp.result_id = hw_reg;
            end
            default: begin
                // Undefined actions echo the ID and change nothing.
            end
        endcase
    end

    assign stk_cmd_g = exec ? stk_cmd : '0;
    assign tbl_wr_g  = exec ? tbl_wr : '0;
    assign hw_next   = exec ? hw_exec : hw_reg;

    ria_free_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_free_stack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (stk_cmd_g),
        .push_id  (in_data_reg.id),
        .top      (stk_top),
        .top_next (stk_top_next),
        .stat     (stk_stat)
    );

    // The table read is addressed for whichever request sits in the input
    // register next cycle, using the state as it will be after this cycle.
    assign in_data_next = accept ? s_payload : in_data_reg;
    assign nid_next     = stk_stat.empty_next ? (hw_next + 1'b1) : stk_top_next;
    assign tbl_rd_addr  = (in_data_next.action == ACT_ALLOC) ? nid_next : in_data_next.id;

    ria_entry_table u_entry_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (tbl_wr_g),
        .wr_addr   (tbl_wr_addr),
        .wr_handle (in_data_reg.handle),
        .rd_addr   (tbl_rd_addr),
        .rd_valid  (tbl_rd_valid),
        .rd_handle (tbl_rd_handle),
        .clearing  (clearing)
    );

    assign in_valid_next  = accept || (in_valid_reg && !exec);
    assign out_valid_next = exec || (out_valid_reg && !m_ready);
    assign out_data_next  = exec ? rsp : out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hw_reg        <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            hw_reg        <= hw_next;
        end
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

endmodule

/* hdl/ria_checker.sv */
// Port-level checks for the recycling ID allocator, bound to its top level.
// Depends on ria_pkg and recycling_id_allocator_defines.svh.
`timescale 1ns / 1ps
`include "recycling_id_allocator_defines.svh"

module ria_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input ria_pkg::ria_req_t s_payload,
    input logic              m_valid,
    input logic              m_ready,
    input ria_pkg::ria_rsp_t m_payload
);
    import ria_pkg::*;

    // A stalled result must be held unchanged.
    `RIA_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload), "stalled result changed")

    // Only defined status codes are reported.
    `RIA_ASSERT_IMPLY(a_status, aclk, aresetn, m_valid, m_payload.status <= ST_FULL, "undefined status code")

    // Exhaustion never reports a usable ID.
    `RIA_ASSERT_IMPLY(a_exh_id, aclk, aresetn, m_valid && (m_payload.status == ST_EXHAUSTED), m_payload.result_id == '0, "exhausted result carries an ID")

    // Any failure returns a zero handle.
    `RIA_ASSERT_IMPLY(a_fail_hdl, aclk, aresetn, m_valid && (m_payload.status != ST_OK), m_payload.result_handle == '0, "failed transaction returned a handle")

endmodule

bind recycling_id_allocator ria_checker u_ria_checker (.*);
